### hdl/wcf_pkg.sv
// Shared types, constants and size functions for the WebM cluster header framer.
`default_nettype none

package wcf_pkg;

    // Field widths
    localparam int PAY_W  = 29;
    localparam int TS_W   = 32;
    localparam int SIZE_W = 31;
    localparam int CODE_W = 40;
    localparam int LEN_W  = 3;
    localparam int POS_W  = 5;

    // Header bytes
    localparam logic [31:0] CLUSTER_ID     = 32'h1F43_B675;
    localparam logic [7:0]  TIMECODE_ID    = 8'hE7;
    localparam logic [7:0]  TIMECODE_SIZE  = 8'h84;
    localparam logic [7:0]  SIMPLEBLOCK_ID = 8'hA3;
    localparam logic [7:0]  TRACK_NUMBER   = 8'h81;
    localparam logic [7:0]  ZERO_BYTE      = 8'h00;
    localparam logic [7:0]  FLAG_KEYFRAME  = 8'h80;
    localparam logic [7:0]  FLAG_INVISIBLE = 8'h08;
    localparam logic [7:0]  FLAG_DISCARD   = 8'h01;

    // Fixed element lengths around the size fields
    localparam logic [POS_W-1:0] ID_BYTES       = 5'd4;
    localparam logic [POS_W-1:0] TIMECODE_BYTES = 5'd6;
    localparam logic [POS_W-1:0] BLOCK_START    = 5'd7;
    localparam logic [SIZE_W-1:0] BLOCK_HDR     = 31'd4;
    localparam logic [SIZE_W-1:0] CLUSTER_FIXED = 31'd7;

    localparam logic [PAY_W-1:0] MAX_PAYLOAD_RESET = 29'd3110400;

    // One frame waiting to be serialized
    typedef struct packed {
        logic              too_large;
        logic [LEN_W-1:0]  cn;
        logic [LEN_W-1:0]  sn;
        logic [CODE_W-1:0] clus_code;
        logic [CODE_W-1:0] blk_code;
        logic [TS_W-1:0]   ts;
        logic [7:0]        flags;
    } desc_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Size field byte counts for one maximum payload
    typedef struct packed {
        logic [LEN_W-1:0] sn;
        logic [LEN_W-1:0] cn;
    } len_pair_t;

    // Smallest EBML vint length that holds v without the all-ones code.
    function automatic logic [LEN_W-1:0] vint_len(input logic [SIZE_W-1:0] v);
        logic [SIZE_W:0]   vp;
        logic [LEN_W-1:0]  n;
        vp = {1'b0, v} + 32'd1;
        n  = 3'd1;
        if (vp >= 32'd128)       n = 3'd2;
        if (vp >= 32'd16384)     n = 3'd3;
        if (vp >= 32'd2097152)   n = 3'd4;
        if (vp >= 32'd268435456) n = 3'd5;
        return n;
    endfunction

    // Byte counts of block size and cluster size for a maximum payload.
    function automatic len_pair_t size_lens(input logic [PAY_W-1:0] maxp);
        logic [SIZE_W-1:0] smax;
        logic [SIZE_W-1:0] cmax;
        len_pair_t         r;
        smax = {2'b00, maxp} + BLOCK_HDR;
        r.sn = vint_len(smax);
        cmax = smax + CLUSTER_FIXED + {28'd0, r.sn};
        r.cn = vint_len(cmax);
        return r;
    endfunction

    // Value with the vint length marker set.
    function automatic logic [CODE_W-1:0] vint_code(input logic [SIZE_W-1:0] v,
                                                     input logic [LEN_W-1:0]  n);
        logic [CODE_W-1:0] c;
        c = {9'd0, v};
        case (n)
            3'd1:    c[7]  = 1'b1;
            3'd2:    c[14] = 1'b1;
            3'd3:    c[21] = 1'b1;
            3'd4:    c[28] = 1'b1;
            default: c[35] = 1'b1;
        endcase
        return c;
    endfunction

    localparam len_pair_t RESET_LENS = size_lens(MAX_PAYLOAD_RESET);

endpackage

`default_nettype wire

### hdl/wcf_front.sv
// Front end: holds the maximum payload, clamps each frame and builds its size codes.
`default_nettype none

module wcf_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [wcf_pkg::PAY_W-1:0]   cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [wcf_pkg::PAY_W-1:0]   payload_bytes,
    input  wire logic [wcf_pkg::TS_W-1:0]    time_stamp,
    input  wire logic                        keyframe,
    input  wire logic                        invisible,
    input  wire logic                        discardable,
    input  wire wcf_pkg::q_stat_t            q_stat,
    output logic                             push,
    output wcf_pkg::desc_t                   push_desc
);

    logic [wcf_pkg::PAY_W-1:0]  max_reg;
    wcf_pkg::len_pair_t         lens_reg;
    logic                       too_large;
    logic [wcf_pkg::PAY_W-1:0]  pay_clamped;
    logic [wcf_pkg::SIZE_W-1:0] blk_size;
    logic [wcf_pkg::SIZE_W-1:0] clus_size;

    // Configuration register with its size field lengths worked out at write time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= wcf_pkg::MAX_PAYLOAD_RESET;
            lens_reg <= wcf_pkg::RESET_LENS;
        end
        else if (cfg_we)
        begin
            max_reg  <= cfg_wdata;
            lens_reg <= wcf_pkg::size_lens(cfg_wdata);
        end
    end

    // Clamp the payload and form both sizes.
    always_comb
    begin
        too_large   = (payload_bytes > max_reg);
        pay_clamped = too_large ? max_reg : payload_bytes;
        blk_size    = {2'b00, pay_clamped} + wcf_pkg::BLOCK_HDR;
        clus_size   = blk_size + wcf_pkg::CLUSTER_FIXED + {28'd0, lens_reg.sn};
    end

    // Descriptor handed to the queue.
    always_comb
    begin
        push_desc.too_large = too_large;
        push_desc.cn        = lens_reg.cn;
        push_desc.sn        = lens_reg.sn;
        push_desc.clus_code = wcf_pkg::vint_code(clus_size, lens_reg.cn);
        push_desc.blk_code  = wcf_pkg::vint_code(blk_size, lens_reg.sn);
        push_desc.ts        = time_stamp;
        push_desc.flags     = (keyframe    ? wcf_pkg::FLAG_KEYFRAME  : wcf_pkg::ZERO_BYTE)
                            | (invisible   ? wcf_pkg::FLAG_INVISIBLE : wcf_pkg::ZERO_BYTE)
                            | (discardable ? wcf_pkg::FLAG_DISCARD   : wcf_pkg::ZERO_BYTE);
    end

    assign in_ready = !q_stat.full;
    assign push     = in_valid && !q_stat.full;

endmodule

`default_nettype wire

### hdl/wcf_queue.sv
// Two-entry frame descriptor queue between front end and serializer.
`default_nettype none

module wcf_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire wcf_pkg::desc_t      push_desc,
    input  wire logic                pop,
    output wcf_pkg::desc_t           pop_desc,
    output wcf_pkg::q_stat_t         q_stat
);

    wcf_pkg::desc_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    // Entry storage; no reset needed on payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign pop_desc     = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("descriptor queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("descriptor queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("descriptor queue count out of range");
`endif

endmodule

`default_nettype wire

### hdl/wcf_back.sv
// Serializer: walks one header byte per cycle into the output register while the receiver does not stall.
`default_nettype none

module wcf_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wcf_pkg::q_stat_t     q_stat,
    input  wire wcf_pkg::desc_t       pop_desc,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast,
    output logic                      m_tuser
);

    wcf_pkg::desc_t             desc_reg;
    logic                       busy_reg;
    logic [wcf_pkg::POS_W-1:0]  pos_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_last_reg;
    logic                       out_tl_reg;

    logic                       step;
    logic [7:0]                 cur_byte;
    logic                       cur_last;
    logic [wcf_pkg::POS_W-1:0]  clus_end;
    logic [wcf_pkg::POS_W-1:0]  rel_tc;
    logic [wcf_pkg::POS_W-1:0]  rel_blk;
    logic [wcf_pkg::POS_W-1:0]  rel_tail;
    logic [wcf_pkg::POS_W-1:0]  hdr_len;
    logic [wcf_pkg::LEN_W-1:0]  vint_idx;

    function automatic logic [7:0] code_byte(input logic [wcf_pkg::CODE_W-1:0] c,
                                             input logic [wcf_pkg::LEN_W-1:0]  i);
        logic [7:0] b;
        case (i)
            3'd0:    b = c[7:0];
            3'd1:    b = c[15:8];
            3'd2:    b = c[23:16];
            3'd3:    b = c[31:24];
            default: b = c[39:32];
        endcase
        return b;
    endfunction

    // Segment offsets for the current frame.
    always_comb
    begin
        clus_end = wcf_pkg::ID_BYTES + {2'b00, desc_reg.cn};
        rel_tc   = pos_reg - clus_end;
        rel_blk  = rel_tc - wcf_pkg::BLOCK_START;
        rel_tail = rel_blk - {2'b00, desc_reg.sn};
        hdr_len  = clus_end + wcf_pkg::BLOCK_START + {2'b00, desc_reg.sn} + 5'd4;
    end

    // Pick the byte at the current position.
    always_comb
    begin
        cur_byte = wcf_pkg::ZERO_BYTE;
        cur_last = 1'b0;
        vint_idx = 3'd0;
        if (pos_reg < wcf_pkg::ID_BYTES)
        begin
            case (pos_reg[1:0])
                2'd0:    cur_byte = wcf_pkg::CLUSTER_ID[31:24];
                2'd1:    cur_byte = wcf_pkg::CLUSTER_ID[23:16];
                2'd2:    cur_byte = wcf_pkg::CLUSTER_ID[15:8];
                default: cur_byte = wcf_pkg::CLUSTER_ID[7:0];
            endcase
        end
        else if (pos_reg < clus_end)
        begin
            vint_idx = 3'(clus_end - 5'd1 - pos_reg);
            cur_byte = code_byte(desc_reg.clus_code, vint_idx);
        end
        else if (rel_tc < wcf_pkg::BLOCK_START)
        begin
            case (rel_tc[2:0])
                3'd0:    cur_byte = wcf_pkg::TIMECODE_ID;
                3'd1:    cur_byte = wcf_pkg::TIMECODE_SIZE;
                3'd2:    cur_byte = desc_reg.ts[31:24];
                3'd3:    cur_byte = desc_reg.ts[23:16];
                3'd4:    cur_byte = desc_reg.ts[15:8];
                3'd5:    cur_byte = desc_reg.ts[7:0];
                default: cur_byte = wcf_pkg::SIMPLEBLOCK_ID;
            endcase
        end
        else if (rel_blk < {2'b00, desc_reg.sn})
        begin
            vint_idx = 3'(desc_reg.sn - 3'd1 - rel_blk[2:0]);
            cur_byte = code_byte(desc_reg.blk_code, vint_idx);
        end
        else
        begin
            case (rel_tail[1:0])
                2'd0:    cur_byte = wcf_pkg::TRACK_NUMBER;
                2'd1:    cur_byte = wcf_pkg::ZERO_BYTE;
                2'd2:    cur_byte = wcf_pkg::ZERO_BYTE;
                default:
                begin
                    cur_byte = desc_reg.flags;
                    cur_last = 1'b1;
                end
            endcase
        end
    end

    assign step = busy_reg && (!out_valid_reg || m_tready);
    assign pop  = !q_stat.empty && (!busy_reg || (step && cur_last));

    // Sequencer: load a frame, then advance one byte per output slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
        end
        else if (step)
        begin
            if (cur_last)
            begin
                busy_reg <= 1'b0;
            end
            pos_reg <= pos_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= pop_desc;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
            out_tl_reg   <= desc_reg.too_large;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_tl_reg;

`ifndef ASSERT_OFF
    a_pos_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg < hdr_len))
        else $error("byte position past end of header");

    a_last_is_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> ((m_tdata & 8'h76) == 8'h00))
        else $error("last byte carries bits outside the flag set");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cur_last) |-> (pos_reg == hdr_len - 5'd1))
        else $error("frame ends before its header length");
`endif

endmodule

`default_nettype wire

### hdl/webm_cluster_header_framer.sv
// Top level of the WebM cluster header framer.
// Each input transfer on the s_ channel describes one frame: payload length and
// timestamp in s_tdata, keyframe/invisible/discardable flags in s_tuser. For
// each frame the block sends the Cluster header with a single SimpleBlock
// header on the m_ channel, one byte per transfer; m_tlast marks the flags
// byte and m_tuser is set on every byte when the payload was clamped.
// A header is 15 + CN + SN bytes (17 to 25); CN and SN follow from the
// maximum payload written on cfg_we/cfg_wdata (23 bytes after reset).
// An input frame passes the queue, the descriptor register and the output
// register before its first header byte. The serializer emits one byte per
// cycle while m_tready is high, through the single byte lane of the output
// register, and starts the next frame right after the flags byte. A two-entry
// queue lets the front end keep accepting frames while the serializer works
// or the receiver stalls. When m_tready is low the output register holds its
// byte and the queue fills; s_tready drops once it is full. Reset empties the
// queue and output and restores the maximum payload to 3110400 bytes.
`default_nettype none

module webm_cluster_header_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [28:0] cfg_wdata,   // max_payload_bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,     // payload_bytes[28:0], time_stamp[60:29], zero
    input  wire logic [2:0]  s_tuser,     // keyframe[0], invisible[1], discardable[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // out_byte[7:0]
    output logic             m_tlast,
    output logic             m_tuser      // too_large[0]
);

    logic              push;
    logic              pop;
    wcf_pkg::desc_t    push_desc;
    wcf_pkg::desc_t    pop_desc;
    wcf_pkg::q_stat_t  q_stat;

    wcf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .payload_bytes (s_tdata[28:0]),
        .time_stamp    (s_tdata[60:29]),
        .keyframe      (s_tuser[0]),
        .invisible     (s_tuser[1]),
        .discardable   (s_tuser[2]),
        .q_stat        (q_stat),
        .push          (push),
        .push_desc     (push_desc)
    );

    wcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .q_stat    (q_stat)
    );

    wcf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_desc (pop_desc),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### test/tb_webm_cluster_header_framer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the WebM cluster header framer: frames in, predicted header bytes out.

module tb_webm_cluster_header_framer;

    localparam int CLK_HALF    = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 21;
    localparam int PHASE_ITEMS = 22;
    localparam logic [wcf_pkg::PAY_W-1:0] PAY_MASK = '1;

    // One header byte as it should appear on the master side.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       too_large;
    } hdr_byte_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [28:0]      cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata   = '0;
    logic [2:0]       s_tuser   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;
    logic             m_tlast;
    logic             m_tuser;

    // Header bytes still owed by the block, oldest first.
    hdr_byte_t        hdr_q[$];
    hdr_byte_t        got_exp;
    logic [wcf_pkg::PAY_W-1:0] max_payload = wcf_pkg::MAX_PAYLOAD_RESET;
    int unsigned      errors      = 0;
    int unsigned      idle_cycles = 0;
    int unsigned      rx_stall    = 0;
    bit               tx_idle_en  = 1'b1;
    bit               rx_idle_en  = 1'b1;

    always #CLK_HALF clk = ~clk;

    webm_cluster_header_framer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Number of bytes an EBML vint needs, keeping clear of the all-ones code.
    function automatic int unsigned vint_bytes(input longint unsigned v);
        int unsigned n;
        n = 1;
        while (n < 8 && v + 64'd1 >= (64'd1 << (7 * n)))
            n++;
        return n;
    endfunction

    function automatic void push_hdr_byte(input logic [7:0] b, input logic last,
                                          input logic tl);
        hdr_byte_t e;
        e.data      = b;
        e.last      = last;
        e.too_large = tl;
        hdr_q.push_back(e);
    endfunction

    // Size field with its length marker, most significant byte first.
    function automatic void push_size_field(input longint unsigned v, input int unsigned n,
                                            input logic tl);
        longint unsigned coded;
        coded = v | (64'd1 << (7 * n));
        for (int i = int'(n) - 1; i >= 0; i--)
            push_hdr_byte(8'(coded >> (8 * i)), 1'b0, tl);
    endfunction

    // Expected header for one frame under the current maximum payload.
    function automatic void predict_header(input logic [wcf_pkg::PAY_W-1:0] pay,
                                           input logic [wcf_pkg::TS_W-1:0] ts,
                                           input logic [2:0] flags);
        longint unsigned maxp;
        longint unsigned size_pay;
        longint unsigned blk;
        int unsigned     sn;
        int unsigned     cn;
        logic            tl;
        logic [7:0]      fl;
        maxp     = max_payload;
        size_pay = pay;
        tl       = 1'b0;
        if (size_pay > maxp)
        begin
            size_pay = maxp;
            tl       = 1'b1;
        end
        sn  = vint_bytes(maxp + 4);
        cn  = vint_bytes(maxp + 4 + 7 + sn);
        blk = size_pay + 4;
        for (int i = 3; i >= 0; i--)
            push_hdr_byte(wcf_pkg::CLUSTER_ID[8*i +: 8], 1'b0, tl);
        push_size_field(blk + 7 + sn, cn, tl);
        push_hdr_byte(wcf_pkg::TIMECODE_ID, 1'b0, tl);
        push_hdr_byte(wcf_pkg::TIMECODE_SIZE, 1'b0, tl);
        for (int i = 3; i >= 0; i--)
            push_hdr_byte(ts[8*i +: 8], 1'b0, tl);
        push_hdr_byte(wcf_pkg::SIMPLEBLOCK_ID, 1'b0, tl);
        push_size_field(blk, sn, tl);
        push_hdr_byte(wcf_pkg::TRACK_NUMBER, 1'b0, tl);
        push_hdr_byte(wcf_pkg::ZERO_BYTE, 1'b0, tl);
        push_hdr_byte(wcf_pkg::ZERO_BYTE, 1'b0, tl);
        fl = wcf_pkg::ZERO_BYTE;
        if (flags[0])
            fl = fl | wcf_pkg::FLAG_KEYFRAME;
        if (flags[1])
            fl = fl | wcf_pkg::FLAG_INVISIBLE;
        if (flags[2])
            fl = fl | wcf_pkg::FLAG_DISCARD;
        push_hdr_byte(fl, 1'b1, tl);
    endfunction

    // Payload choice that favors legal sizes and the clamp boundary.
    function automatic logic [wcf_pkg::PAY_W-1:0] pick_payload();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return wcf_pkg::PAY_W'($urandom_range(0, max_payload));
            6:                return max_payload;
            7:                return (max_payload == PAY_MASK) ? max_payload
                                                               : max_payload + 29'd1;
            8:                return '0;
            default:          return wcf_pkg::PAY_W'($urandom);
        endcase
    endfunction

    // Maximum payload per phase: size field vint boundaries, the largest and reset values, random.
    function automatic logic [wcf_pkg::PAY_W-1:0] phase_max(input int p);
        case (p)
            0:       return 29'd0;
            1:       return 29'd114;
            2:       return 29'd115;
            3:       return 29'd122;
            4:       return 29'd123;
            5:       return 29'd16369;
            6:       return 29'd16370;
            7:       return 29'd16378;
            8:       return 29'd16379;
            9:       return 29'd2097136;
            10:      return 29'd2097137;
            11:      return 29'd2097146;
            12:      return 29'd2097147;
            13:      return 29'd268435439;
            14:      return 29'd268435440;
            15:      return 29'd268435450;
            16:      return 29'd268435451;
            17:      return PAY_MASK;
            18:      return wcf_pkg::MAX_PAYLOAD_RESET;
            19:      return wcf_pkg::PAY_W'($urandom);
            default: return wcf_pkg::PAY_W'($urandom_range(0, 300));
        endcase
    endfunction

    // Present one frame and hold it until the transfer completes.
    task automatic send_frame(input logic [wcf_pkg::PAY_W-1:0] pay,
                              input logic [wcf_pkg::TS_W-1:0] ts,
                              input logic [2:0] flags);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, ts, pay};
        s_tuser  <= flags;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_header(pay, ts, flags);
    endtask

    // Stop sending and let every owed header byte come out.
    task automatic wait_for_headers();
        s_tvalid <= 1'b0;
        while (hdr_q.size() != 0)
            @(posedge clk);
    endtask

    // Change the maximum payload while the block is idle.
    task automatic set_max_payload(input logic [wcf_pkg::PAY_W-1:0] value);
        wait_for_headers();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        max_payload = value;
        cfg_we      <= 1'b0;
    endtask

    // Directed frames under the reset maximum: field extremes and every flag combination.
    task automatic test_reset_setting();
        send_frame(29'd0, 32'h0000_0000, 3'b000);
        send_frame(wcf_pkg::MAX_PAYLOAD_RESET, 32'hFFFF_FFFF, 3'b111);
        send_frame(wcf_pkg::MAX_PAYLOAD_RESET + 29'd1, 32'h1234_5678, 3'b001);
        send_frame(PAY_MASK, 32'h8000_0001, 3'b010);
        send_frame(29'd1, 32'h7FFF_FFFE, 3'b100);
        send_frame(29'h0AAA_AAAA, 32'hAAAA_5555, 3'b011);
        send_frame(29'h1555_5555, 32'h5555_AAAA, 3'b101);
        send_frame(wcf_pkg::MAX_PAYLOAD_RESET - 29'd1, 32'h0000_00FF, 3'b110);
    endtask

    // Zero maximum: one-byte size fields and every nonzero payload clamped.
    task automatic test_small_max();
        set_max_payload(29'd0);
        send_frame(29'd0, 32'h0102_0304, 3'b111);
        send_frame(29'd1, 32'hFEDC_BA98, 3'b000);
        send_frame(PAY_MASK, 32'hFFFF_FFFF, 3'b101);
    endtask

    // Largest maximum: five-byte size fields and the widest header.
    task automatic test_largest_max();
        set_max_payload(PAY_MASK);
        send_frame(PAY_MASK, 32'hFFFF_FFFF, 3'b111);
        send_frame(29'd0, 32'h0000_0000, 3'b000);
        send_frame(29'h1000_0000, 32'h0F0F_F0F0, 3'b010);
    endtask

    // Random frames over a sweep of maximum payloads; no idling in the last phases.
    task automatic test_random_phases();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            tx_idle_en = (p < NUM_PHASES - 3);
            rx_idle_en = (p < NUM_PHASES - 3);
            set_max_payload(phase_max(p));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_for_headers();
                send_frame(pick_payload(), $urandom, 3'($urandom));
            end
        end
    endtask

    // Receiver: ready with random stall bursts.
    always @(posedge clk)
    begin
        if (rx_stall != 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= $urandom_range(0, 5);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare each output transfer with the oldest owed header byte.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hdr_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected byte, expected none actual %h last %b too_large %b",
                         $time, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                got_exp = hdr_q.pop_front();
                if (m_tdata !== got_exp.data)
                begin
                    errors++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, got_exp.data, m_tdata);
                end
                if (m_tlast !== got_exp.last)
                begin
                    errors++;
                    $display("%0t: last_byte expected %b actual %b",
                             $time, got_exp.last, m_tlast);
                end
                if (m_tuser !== got_exp.too_large)
                begin
                    errors++;
                    $display("%0t: too_large expected %b actual %b",
                             $time, got_exp.too_large, m_tuser);
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_webm_cluster_header_framer NOT OK");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_setting();
        test_small_max();
        test_largest_max();
        test_random_phases();
        wait_for_headers();
        repeat (30) @(posedge clk);
        if (errors == 0 && hdr_q.size() == 0)
            $display("tb_webm_cluster_header_framer OK");
        else
            $display("tb_webm_cluster_header_framer NOT OK");
        $finish;
    end

endmodule
